@@ hw/rtl/compare_feedback_counter_map_defines.svh @@
// Assertion macros for the compare feedback counter map checker.
// Used by cfcm_checker.sv; expects clk_i and rst_ni in scope.
`ifndef COMPARE_FEEDBACK_COUNTER_MAP_DEFINES_SVH
`define COMPARE_FEEDBACK_COUNTER_MAP_DEFINES_SVH

// Clocked property, masked while in reset.
`define CFCM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Signal is unchanged in the cycle after the condition.
`define CFCM_ASSERT_STABLE(lbl, cond, sig, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> $stable(sig)) \
    else $error(msg);

`endif

@@ hw/rtl/cfcm_pkg.sv @@
// Shared types and constants for the compare feedback counter map.
// No dependencies; imported by all RTL modules of the block.
`default_nettype none

package cfcm_pkg;

  localparam int unsigned MapSlotsDef  = 65536;
  localparam int unsigned StrPrefixDef = 32;

  localparam logic [63:0] GoldenHash = 64'h9e3779b185ebca87;
  localparam logic [7:0]  CounterMax = 8'd255;

  localparam int unsigned MulW    = 32;
  localparam int unsigned CmdW    = 3;
  localparam int unsigned InDataW = 288;
  localparam int unsigned SlotW   = 8;
  localparam int unsigned NzW     = 17;
  localparam int unsigned OutDataW = 32;

  typedef enum logic [CmdW-1:0] {
    CMD_INT_CMP   = 3'd0,
    CMD_IND_CALL  = 3'd1,
    CMD_STR_BEGIN = 3'd2,
    CMD_STR_BYTES = 3'd3,
    CMD_CLEAR     = 3'd4,
    CMD_READ      = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_MUL,
    ST_HASH,
    ST_RED,
    ST_RD,
    ST_RMW,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

@@ hw/rtl/cfcm_mul32.sv @@
// Registered 32x32 unsigned multiplier shared for the partial products
// of the string seed hash. Depends on cfcm_pkg.
`default_nettype none

module cfcm_mul32
  import cfcm_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic [MulW-1:0]   a_i,
  input  wire logic [MulW-1:0]   b_i,
  output logic      [2*MulW-1:0] p_o
);

  logic [2*MulW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= (2*MulW)'(a_i) * (2*MulW)'(b_i);
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

@@ hw/rtl/compare_feedback_counter_map.sv @@
// Compare feedback counter map: sequencer, slot memory, hash and count logic.
// Depends on cfcm_pkg and cfcm_mul32.
//
//   port group  dir  tdata fields (low bit up)                          tuser
//   s_axis      in   trace_id, arg_a, arg_b, len_first, len_second,     command
//                    byte_first, byte_second, slot_index (288 bits)
//   m_axis      out  slot_value, nonzero_count, zero pad (32 bits)      -
//
// One word at a time; s_axis_tready is high only when the sequencer is idle.
// Compare/call/read: the key is reduced to a slot index, the slot is read, then
// bumped or returned. String begin: three 32x32 partial products, then the seed,
// bumped when the prefix limit is zero; byte pair: one bump, with the closing bump
// on the last pair, none past the limit. A non power of two map adds residue
// folding per slot lookup. Clear and reset both run a clearing pass over the memory.
// A finished result waits in the output register; a new word is taken meanwhile.
`default_nettype none

module compare_feedback_counter_map
  import cfcm_pkg::*;
#(
  parameter int unsigned MAP_SLOTS     = MapSlotsDef,
  parameter int unsigned STRING_PREFIX = StrPrefixDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // trace_id, arg_a, arg_b, len_first, len_second, byte_first, byte_second, slot_index
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,
  // command
  input  wire logic [CmdW-1:0]     s_axis_tuser_i,
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // slot_value, nonzero_count, zero pad
  output logic [OutDataW-1:0]      m_axis_tdata_o
);

  localparam int unsigned AddrW = $clog2(MAP_SLOTS);
  localparam bit SlotsPow2 = (MAP_SLOTS & (MAP_SLOTS - 1)) == 0;
  localparam int unsigned LimW = $clog2(STRING_PREFIX + 1);
  localparam int unsigned PosW = (LimW > 3) ? LimW : 3;
  localparam int unsigned CntBits = $clog2(MAP_SLOTS + 1);
  localparam int unsigned CntW = (CntBits > NzW) ? CntBits : NzW;
  localparam int unsigned PadW = OutDataW - NzW - SlotW;
  localparam int unsigned RemW = AddrW + 7;
  localparam logic [AddrW:0]   SlotsVal = (AddrW + 1)'(MAP_SLOTS);
  localparam logic [AddrW-1:0] LastSlot = AddrW'(MAP_SLOTS - 1);
  localparam logic [MulW-1:0]  GoldLo = GoldenHash[MulW-1:0];
  localparam logic [MulW-1:0]  GoldHi = GoldenHash[2*MulW-1:MulW];

  // 2^j mod MAP_SLOTS, for the residue table
  function automatic logic [AddrW-1:0] pow2_mod(int unsigned j);
    logic [AddrW:0] r;
    r = (AddrW + 1)'(1);
    for (int unsigned k = 0; k < j; k++) begin
      r = {r[AddrW-1:0], 1'b0};
      if (r >= SlotsVal) r = r - SlotsVal;
    end
    return r[AddrW-1:0];
  endfunction

  // input fields
  logic [63:0] in_id, in_a, in_b;
  logic [31:0] in_l1, in_l2;
  logic [7:0]  in_b1, in_b2;
  logic [15:0] in_sidx;
  logic        accept;

  assign in_id   = s_axis_tdata_i[63:0];
  assign in_a    = s_axis_tdata_i[127:64];
  assign in_b    = s_axis_tdata_i[191:128];
  assign in_l1   = s_axis_tdata_i[223:192];
  assign in_l2   = s_axis_tdata_i[255:224];
  assign in_b1   = s_axis_tdata_i[263:256];
  assign in_b2   = s_axis_tdata_i[271:264];
  assign in_sidx = s_axis_tdata_i[287:272];

  state_e state_q, state_d;

  // control state
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [PosW-1:0]  pos_q, pos_d, lim_q, lim_d;
  logic [AddrW-1:0] clr_idx_q, clr_idx_d;
  logic             clr_cmd_q, clr_cmd_d;
  logic [1:0]       mstep_q, mstep_d;
  logic [5:0]       bitcnt_q, bitcnt_d;
  logic [RemW-1:0]  rem_q, rem_d;
  logic             m_valid_q, m_valid_d;

  // datapath registers
  cmd_e             cmd_q;
  logic [63:0]      id_q;
  logic [31:0]      l1_q, l2_q;
  logic [7:0]       b1_q, b2_q;
  logic [63:0]      key_q, key_d;
  logic [63:0]      hash_q, hash_d;
  logic [63:0]      acc_q, acc_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic             rd_only_q, rd_only_d;
  logic             fin_q, fin_d;
  logic [SlotW-1:0] val_q, val_d;
  logic [SlotW-1:0] out_val_q, out_val_d;
  logic [NzW-1:0]   out_cnt_q, out_cnt_d;

  // slot memory
  logic [SlotW-1:0] mem [MAP_SLOTS];
  logic [SlotW-1:0] rdata_q;
  logic             mem_we;
  logic [AddrW-1:0] mem_wa;
  logic [SlotW-1:0] mem_wd;

  // shared multiplier
  logic [MulW-1:0]   mul_a, mul_b;
  logic [2*MulW-1:0] mul_p;

  // combinational helpers
  logic [SlotW-1:0] bump_val;
  logic [5:0]       sh1, sh2;
  logic [2:0]       pos_rot;
  logic [63:0]      hash_fold, key_byte, hash_begin;
  logic [31:0]      lmin;
  logic [PosW-1:0]  lim_new;
  logic [AddrW-1:0] pw_tab [64];
  logic [RemW-1:0]  fold_sum;
  logic [2:0]       sub_sh;
  logic [RemW-1:0]  sub_val;
  logic [RemW-1:0]  sub_next;

  cfcm_mul32 u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  for (genvar gj = 0; gj < 64; gj++) begin : g_pw
    assign pw_tab[gj] = pow2_mod(gj);
  end

  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign bump_val = (rdata_q == CounterMax) ? SlotW'(1) : rdata_q + SlotW'(1);

  // byte fold: first byte at lane i mod 8, second at lane (i+3) mod 8
  assign pos_rot    = pos_q[2:0] + 3'd3;
  assign sh1        = {pos_q[2:0], 3'b000};
  assign sh2        = {pos_rot, 3'b000};
  assign hash_fold  = hash_q ^ (64'(b1_q) << sh1) ^ (64'(b2_q) << sh2);
  assign key_byte   = hash_fold + 64'(pos_q);
  assign hash_begin = acc_q ^ {l1_q, 32'd0} ^ {31'd0, l2_q, 1'b0};
  assign lmin       = (l1_q < l2_q) ? l1_q : l2_q;
  assign lim_new    = (lmin > 32'(STRING_PREFIX)) ? PosW'(STRING_PREFIX) : PosW'(lmin);

  // residue fold: eight key bits a cycle, each set bit adds 2^j mod MAP_SLOTS
  always_comb begin
    fold_sum = rem_q;
    for (int t = 0; t < 8; t++) begin
      if (key_q[t]) begin
        fold_sum = fold_sum + RemW'(pw_tab[{bitcnt_q[2:0], 3'(t)}]);
      end
    end
  end

  // folded sum is below 64 slots' worth; strip 32x, 16x, ... 1x of MAP_SLOTS
  assign sub_sh   = 3'(6'd13 - bitcnt_q);
  assign sub_val  = RemW'(MAP_SLOTS) << sub_sh;
  assign sub_next = (rem_q >= sub_val) ? rem_q - sub_val : rem_q;

  assign s_axis_tready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    pos_d     = pos_q;
    lim_d     = lim_q;
    clr_idx_d = clr_idx_q;
    clr_cmd_d = clr_cmd_q;
    mstep_d   = mstep_q;
    bitcnt_d  = bitcnt_q;
    rem_d     = rem_q;
    key_d     = key_q;
    hash_d    = hash_q;
    acc_d     = acc_q;
    idx_d     = idx_q;
    rd_only_d = rd_only_q;
    fin_d     = fin_q;
    val_d     = val_q;
    out_val_d = out_val_q;
    out_cnt_d = out_cnt_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    mem_we    = 1'b0;
    mem_wa    = idx_q;
    mem_wd    = bump_val;
    mul_a     = '0;
    mul_b     = '0;

    case (state_q)
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_wa    = clr_idx_q;
        mem_wd    = '0;
        clr_idx_d = clr_idx_q + AddrW'(1);
        if (clr_idx_q == LastSlot) begin
          clr_idx_d = '0;
          val_d     = '0;
          state_d   = clr_cmd_q ? ST_DONE : ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          val_d     = '0;
          fin_d     = 1'b0;
          rd_only_d = 1'b0;
          case (cmd_e'(s_axis_tuser_i))
            CMD_INT_CMP: begin
              key_d   = in_id ^ in_a ^ {in_b[62:0], 1'b0};
              state_d = ST_RED;
            end
            CMD_IND_CALL: begin
              key_d   = in_id ^ {in_a[62:0], 1'b0};
              state_d = ST_RED;
            end
            CMD_STR_BEGIN: begin
              mstep_d = '0;
              state_d = ST_MUL;
            end
            CMD_STR_BYTES: begin
              state_d = ST_HASH;
            end
            CMD_CLEAR: begin
              clr_cmd_d = 1'b1;
              clr_idx_d = '0;
              cnt_d     = '0;
              state_d   = ST_CLR;
            end
            CMD_READ: begin
              key_d     = 64'(in_sidx);
              rd_only_d = 1'b1;
              state_d   = ST_RED;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end

      // id * golden mod 2^64 from three 32x32 partial products
      ST_MUL: begin
        case (mstep_q)
          2'd0: begin
            mul_a = id_q[MulW-1:0];
            mul_b = GoldLo;
          end
          2'd1: begin
            mul_a = id_q[2*MulW-1:MulW];
            mul_b = GoldLo;
            acc_d = mul_p;
          end
          2'd2: begin
            mul_a = id_q[MulW-1:0];
            mul_b = GoldHi;
            acc_d = acc_q + {mul_p[MulW-1:0], {MulW{1'b0}}};
          end
          default: begin
            acc_d   = acc_q + {mul_p[MulW-1:0], {MulW{1'b0}}};
            state_d = ST_HASH;
          end
        endcase
        mstep_d = mstep_q + 2'd1;
      end

      ST_HASH: begin
        state_d = ST_DONE;
        case (cmd_q)
          CMD_STR_BEGIN: begin
            hash_d = hash_begin;
            lim_d  = lim_new;
            pos_d  = '0;
            if (lim_new == '0) begin
              key_d   = hash_begin;
              state_d = ST_RED;
            end
          end
          CMD_STR_BYTES: begin
            if (pos_q < lim_q) begin
              hash_d  = hash_fold;
              key_d   = key_byte;
              pos_d   = pos_q + PosW'(1);
              fin_d   = (pos_q + PosW'(1)) == lim_q;
              state_d = ST_RED;
            end
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end

      ST_RED: begin
        if (SlotsPow2) begin
          idx_d   = key_q[AddrW-1:0];
          state_d = ST_RD;
        end else if (bitcnt_q < 6'd8) begin
          rem_d    = fold_sum;
          key_d    = {8'd0, key_q[63:8]};
          bitcnt_d = bitcnt_q + 6'd1;
        end else begin
          rem_d    = sub_next;
          bitcnt_d = bitcnt_q + 6'd1;
          if (bitcnt_q == 6'd13) begin
            idx_d    = AddrW'(sub_next);
            rem_d    = '0;
            bitcnt_d = '0;
            state_d  = ST_RD;
          end
        end
      end

      ST_RD: begin
        state_d = ST_RMW;
      end

      ST_RMW: begin
        if (rd_only_q) begin
          val_d   = rdata_q;
          state_d = ST_DONE;
        end else begin
          mem_we = 1'b1;
          val_d  = bump_val;
          if (rdata_q == '0) begin
            cnt_d = cnt_q + CntW'(1);
          end
          if (fin_q) begin
            // closing bump of the string on the plain hash
            fin_d   = 1'b0;
            key_d   = hash_q;
            state_d = ST_RED;
          end else begin
            state_d = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        if (!m_valid_q || m_axis_tready_i) begin
          out_val_d = val_q;
          out_cnt_d = cnt_q[NzW-1:0];
          m_valid_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLR;
      cnt_q     <= '0;
      pos_q     <= '0;
      lim_q     <= '0;
      clr_idx_q <= '0;
      clr_cmd_q <= 1'b0;
      mstep_q   <= '0;
      bitcnt_q  <= '0;
      rem_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      pos_q     <= pos_d;
      lim_q     <= lim_d;
      clr_idx_q <= clr_idx_d;
      clr_cmd_q <= clr_cmd_d;
      mstep_q   <= mstep_d;
      bitcnt_q  <= bitcnt_d;
      rem_q     <= rem_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_e'(s_axis_tuser_i);
      id_q  <= in_id;
      l1_q  <= in_l1;
      l2_q  <= in_l2;
      b1_q  <= in_b1;
      b2_q  <= in_b2;
    end
    key_q     <= key_d;
    hash_q    <= hash_d;
    acc_q     <= acc_d;
    idx_q     <= idx_d;
    rd_only_q <= rd_only_d;
    fin_q     <= fin_d;
    val_q     <= val_d;
    out_val_q <= out_val_d;
    out_cnt_q <= out_cnt_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_q <= mem[idx_q];
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{PadW{1'b0}}, out_cnt_q, out_val_q};

endmodule

`default_nettype wire

@@ hw/rtl/cfcm_checker.sv @@
// Port-level checker for compare_feedback_counter_map, bound to the top level.
// Depends on cfcm_pkg and compare_feedback_counter_map_defines.svh.
`default_nettype none

`include "compare_feedback_counter_map_defines.svh"

module cfcm_checker
  import cfcm_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_axis_tvalid_i,
  input wire logic                s_axis_tready_o,
  input wire logic                m_axis_tvalid_o,
  input wire logic                m_axis_tready_i,
  input wire logic [OutDataW-1:0] m_axis_tdata_o
);

  // an offered result is never withdrawn
  `CFCM_ASSERT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o, "result word dropped while stalled")

  `CFCM_ASSERT_STABLE(a_out_data, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tdata_o, "result word changed while stalled")

  // each word occupies the sequencer until its processing is finished
  `CFCM_ASSERT(a_one_word, s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o, "input taken on back-to-back cycles")

  // a nonzero slot value means at least one slot is counted
  `CFCM_ASSERT(a_count_hit, m_axis_tvalid_o && (m_axis_tdata_o[7:0] != 8'd0) |-> (m_axis_tdata_o[24:8] != 17'd0), "nonzero slot with zero count")

endmodule

bind compare_feedback_counter_map cfcm_checker u_cfcm_checker (.*);

`default_nettype wire
